/* hdl/r2h_pkg.sv */
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared types and constants of the RGBA to HSV converter pipeline.
// ----------------------------------------------------------------------------
package r2h_pkg;

  // divider pipeline shape: hue gets HUE_STEPS quotient bits per stage,
  // saturation one bit per stage
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned HUE_STEPS  = 2;
  localparam int unsigned HUE_W      = 16;
  localparam int unsigned SAT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_DELTA_FLOOR = 1'b0,
    CFG_SAT_VALUE_FLOOR = 1'b1
  } r2h_cfg_idx_e;

  // payload carried from stage to stage
  typedef struct packed {
    logic [10:0]      hue_rem;   // partial remainder, always below hue_div
    logic [10:0]      hue_div;   // six times delta
    logic [HUE_W-1:0] hue_quo;   // quotient bits gathered so far
    logic [7:0]       sat_rem;   // partial remainder, always below sat_div
    logic [7:0]       sat_div;   // max of the channels
    logic [7:0]       sat_low;   // dividend bits still to shift in
    logic [SAT_W-1:0] sat_quo;
    logic             hue_zero;
    logic             sat_zero;
    logic [7:0]       value;
    logic [7:0]       alpha;
  } r2h_work_t;

endpackage

/* hdl/r2h_if.sv */
// ----------------------------------------------------------------------------
// r2h_if
// Stream interfaces of the converter: RGBA pixel beats in, HSV beats out.
// ----------------------------------------------------------------------------
interface r2h_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

interface r2h_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue_out;
  logic [7:0]  sat_out;
  logic [7:0]  value_out;
  logic [7:0]  alpha_out;

  modport source (output valid, output hue_out, output sat_out, output value_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input hue_out, input sat_out, input value_out,
                  input alpha_out, output ready);
endinterface

/* hdl/r2h_prep.sv */
// ----------------------------------------------------------------------------
// r2h_prep
// First stage: max, min, delta, hue numerator and both divider setups.
// ----------------------------------------------------------------------------
module r2h_prep import r2h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic [7:0]  hue_floor_i,
  input  logic [7:0]  sat_floor_i,
  output logic        valid_o,
  input  logic        ready_i,
  output r2h_work_t   work_o
);

  logic              valid_q;
  r2h_work_t         work_q, work_d;
  logic [7:0]        hi, lo, delta;
  logic              red_max, green_max;
  logic signed [11:0] r_s, g_s, b_s, d_s, n_s, n_w;
  logic [10:0]       d6;
  logic [15:0]       sat_dvd;

  // max, min with red winning ties over green, green over blue
  always_comb begin
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    if (red_max) begin
      hi = red_i;
    end else if (green_max) begin
      hi = green_i;
    end else begin
      hi = blue_i;
    end
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    delta = hi - lo;
  end

  // hue numerator, wrapped into [0, 6*delta)
  always_comb begin
    r_s = signed'({4'b0, red_i});
    g_s = signed'({4'b0, green_i});
    b_s = signed'({4'b0, blue_i});
    d_s = signed'({4'b0, delta});
    d6  = {1'b0, delta, 2'b0} + {2'b0, delta, 1'b0};
    if (red_max) begin
      n_s = g_s - b_s;
    end else if (green_max) begin
      n_s = (d_s <<< 1) + (b_s - r_s);
    end else begin
      n_s = (d_s <<< 2) + (r_s - g_s);
    end
    n_w = n_s[11] ? n_s + signed'({1'b0, d6}) : n_s;
  end

  // divider setup for both quotients
  always_comb begin
    sat_dvd          = {delta, 8'b0} - {8'b0, delta};
    work_d.hue_rem   = n_w[10:0];
    work_d.hue_div   = d6;
    work_d.hue_quo   = '0;
    work_d.sat_rem   = sat_dvd[15:8];
    work_d.sat_div   = hi;
    work_d.sat_low   = sat_dvd[7:0];
    work_d.sat_quo   = '0;
    work_d.hue_zero  = (delta == 8'd0) || (delta < hue_floor_i);
    work_d.sat_zero  = (hi == 8'd0) || (hi < sat_floor_i);
    work_d.value     = hi;
    work_d.alpha     = alpha_i;
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

/* hdl/r2h_div_stage.sv */
// ----------------------------------------------------------------------------
// r2h_div_stage
// One divider stage: restoring steps for hue and one for saturation.
// ----------------------------------------------------------------------------
module r2h_div_stage import r2h_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  r2h_work_t work_i,
  output logic      valid_o,
  input  logic      ready_i,
  output r2h_work_t work_o
);

  logic      valid_q;
  r2h_work_t work_q, work_d;

  // restoring division steps
  always_comb begin
    logic [11:0] trial;
    logic [8:0]  strial;
    work_d = work_i;
    for (int s = 0; s < HUE_STEPS; s++) begin
      trial = {work_d.hue_rem, 1'b0};
      if (trial >= {1'b0, work_d.hue_div}) begin
        work_d.hue_rem = 11'(trial - {1'b0, work_d.hue_div});
        work_d.hue_quo = {work_d.hue_quo[14:0], 1'b1};
      end else begin
        work_d.hue_rem = trial[10:0];
        work_d.hue_quo = {work_d.hue_quo[14:0], 1'b0};
      end
    end
    strial = {work_d.sat_rem, work_d.sat_low[7]};
    if (strial >= {1'b0, work_d.sat_div}) begin
      work_d.sat_rem = 8'(strial - {1'b0, work_d.sat_div});
      work_d.sat_quo = {work_d.sat_quo[6:0], 1'b1};
    end else begin
      work_d.sat_rem = strial[7:0];
      work_d.sat_quo = {work_d.sat_quo[6:0], 1'b0};
    end
    work_d.sat_low = {work_d.sat_low[6:0], 1'b0};
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

/* hdl/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGBA to HSV, one pixel per clock unless stalled, alpha passed through.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  pix_i    | in  | red_in, green_in, blue_in, alpha_in (8 bits each)
//  hsv_o    | out | hue_out (16), sat_out, value_out, alpha_out (8 each)
//  cfg_*    | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One pixel per clock while hsv_o is ready; the prep register feeds the
// DIV_STAGES restoring divider stages (two hue bits and one saturation bit per
// stage). Reset clears all valid bits and loads both floors with 3. Each stage
// holds its beat while the next is full, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import r2h_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  r2h_pix_if.sink              pix_i,
  r2h_hsv_if.source            hsv_o
);

  logic [7:0] hue_floor_q, sat_floor_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_floor_q <= 8'd3;
      sat_floor_q <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (r2h_cfg_idx_e'(cfg_idx_i))
        CFG_HUE_DELTA_FLOOR: hue_floor_q <= cfg_wdata_i;
        CFG_SAT_VALUE_FLOOR: sat_floor_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic      valid_s [DIV_STAGES+1];
  logic      ready_s [DIV_STAGES+1];
  r2h_work_t work_s  [DIV_STAGES+1];

  // front stage
  r2h_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pix_i.valid),
    .ready_o     (pix_i.ready),
    .red_i       (pix_i.red_in),
    .green_i     (pix_i.green_in),
    .blue_i      (pix_i.blue_in),
    .alpha_i     (pix_i.alpha_in),
    .hue_floor_i (hue_floor_q),
    .sat_floor_i (sat_floor_q),
    .valid_o     (valid_s[0]),
    .ready_i     (ready_s[0]),
    .work_o      (work_s[0])
  );

  // divider pipeline
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    r2h_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .work_i  (work_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .work_o  (work_s[k+1])
    );
  end

  // output beat from the last stage register
  assign ready_s[DIV_STAGES] = hsv_o.ready;
  assign hsv_o.valid     = valid_s[DIV_STAGES];
  assign hsv_o.hue_out   = work_s[DIV_STAGES].hue_zero ? '0 : work_s[DIV_STAGES].hue_quo;
  assign hsv_o.sat_out   = work_s[DIV_STAGES].sat_zero ? '0 : work_s[DIV_STAGES].sat_quo;
  assign hsv_o.value_out = work_s[DIV_STAGES].value;
  assign hsv_o.alpha_out = work_s[DIV_STAGES].alpha;

endmodule

/* bench/rgb_to_hsv_converter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Self-checking bench for the RGBA to HSV converter. RGBA beats go in from a
// pending queue, and each accepted pixel is converted by an in-bench HSV
// predictor. Every output beat is checked field by field against the oldest
// predicted HSV beat. The run steps through several floor settings and
// through several idle and stall mixes on both streams.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb import r2h_pkg::*;;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned BEATS_PER_PHASE = 240;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  value;
    logic [7:0]  alpha;
  } hsv_t;

  // corners, channel ties, floor boundaries and the negative hue wrap
  localparam int unsigned CORNER_COUNT = 22;
  localparam rgba_t CORNER_PX [CORNER_COUNT] = '{
    {8'h00, 8'h00, 8'h00, 8'h00},   // black
    {8'hff, 8'hff, 8'hff, 8'hff},   // white
    {8'hff, 8'h00, 8'h00, 8'h80},   // pure red
    {8'h00, 8'hff, 8'h00, 8'h01},   // pure green
    {8'h00, 8'h00, 8'hff, 8'hfe},   // pure blue
    {8'hff, 8'hff, 8'h00, 8'h7f},   // red and green tie
    {8'h00, 8'hff, 8'hff, 8'h55},   // green and blue tie
    {8'hff, 8'h00, 8'hff, 8'haa},   // red and blue tie
    {8'h80, 8'h80, 8'h80, 8'h33},   // gray
    {8'h0a, 8'h09, 8'h09, 8'hcc},   // delta 1, under hue floor
    {8'h0c, 8'h0a, 8'h0a, 8'h0f},   // delta 2, under hue floor
    {8'h0d, 8'h0a, 8'h0a, 8'hf0},   // delta 3, at hue floor
    {8'h02, 8'h01, 8'h00, 8'h10},   // max under sat floor
    {8'h03, 8'h00, 8'h00, 8'h20},   // max at sat floor
    {8'hff, 8'h00, 8'h01, 8'h40},   // red max, green below blue: wraps
    {8'hff, 8'h01, 8'h00, 8'h02},
    {8'h00, 8'h01, 8'hff, 8'h04},
    {8'h01, 8'hff, 8'h00, 8'h08},
    {8'hc8, 8'h32, 8'h64, 8'h5a},
    {8'h55, 8'haa, 8'h33, 8'ha5},
    {8'haa, 8'h55, 8'hcc, 8'h3c},
    {8'h01, 8'h00, 8'h00, 8'hc3}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_wdata_i;

  r2h_pix_if pix ();
  r2h_hsv_if hsv ();

  rgb_to_hsv_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix),
    .hsv_o      (hsv)
  );

  // floors as the block holds them
  logic [7:0] model_hue_floor = 8'd3;
  logic [7:0] model_sat_floor = 8'd3;

  rgba_t pixel_pending_q [$];
  hsv_t  hsv_expected_q [$];

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned pixels_queued   = 0;
  int unsigned pixels_in       = 0;
  int unsigned hsv_beats       = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  bit          pix_taken       = 1'b0;

  rgba_t next_px;
  hsv_t  got_hsv;
  hsv_t  want_hsv;

  // hue as a 16-bit fraction of a turn, saturation scaled to 255
  function automatic hsv_t predict_hsv(rgba_t px, logic [7:0] hue_floor,
                                       logic [7:0] sat_floor);
    int   r, g, b, hi, lo, delta, turn;
    hsv_t res;
    r  = int'(px.red);
    g  = int'(px.green);
    b  = int'(px.blue);
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    res.hue = '0;
    if (delta != 0 && delta >= int'(hue_floor)) begin
      // ties go to red, then green
      if (r == hi) begin
        turn = g - b;
      end else if (g == hi) begin
        turn = 2 * delta + b - r;
      end else begin
        turn = 4 * delta + r - g;
      end
      if (turn < 0) turn += 6 * delta;
      res.hue = 16'((turn << 16) / (6 * delta));
    end
    res.sat = '0;
    if (hi != 0 && hi >= int'(sat_floor)) res.sat = 8'((delta * 255) / hi);
    res.value = 8'(hi);
    res.alpha = px.alpha;
    return res;
  endfunction

  // mostly a rail value, sometimes anything
  function automatic logic [7:0] rail_or_any();
    case ($urandom_range(2))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_pixel(rgba_t px);
    pixel_pending_q.push_back(px);
    pixels_queued++;
  endtask

  // wait for every queued pixel to come out, then let the pipe settle
  task automatic drain();
    wait (hsv_beats >= pixels_queued);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // pixel beat driver and output stall, both on the falling edge
  always @(negedge clk_i) begin
    if (!pix.valid || pix_taken) begin
      if (pixel_pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_px       = pixel_pending_q.pop_front();
        pix.valid    <= 1'b1;
        pix.red_in   <= next_px.red;
        pix.green_in <= next_px.green;
        pix.blue_in  <= next_px.blue;
        pix.alpha_in <= next_px.alpha;
      end else begin
        pix.valid <= 1'b0;
      end
    end
    pix_taken = 1'b0;
    hsv.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // input capture, prediction and output check on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        hsv_expected_q.push_back(predict_hsv({pix.red_in, pix.green_in, pix.blue_in,
                                              pix.alpha_in},
                                             model_hue_floor, model_sat_floor));
        pix_taken = 1'b1;
        pixels_in++;
      end
      if (hsv.valid && hsv.ready) begin
        got_hsv = {hsv.hue_out, hsv.sat_out, hsv.value_out, hsv.alpha_out};
        hsv_beats++;
        if (hsv_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected hsv beat: hue %h sat %h value %h alpha %h",
                     got_hsv.hue, got_hsv.sat, got_hsv.value, got_hsv.alpha);
        end else begin
          want_hsv = hsv_expected_q.pop_front();
          if (got_hsv.hue !== want_hsv.hue || got_hsv.sat !== want_hsv.sat ||
              got_hsv.value !== want_hsv.value || got_hsv.alpha !== want_hsv.alpha) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("beat %0d: want hue %h sat %h value %h alpha %h, got %h %h %h %h",
                       hsv_beats, want_hsv.hue, want_hsv.sat, want_hsv.value,
                       want_hsv.alpha, got_hsv.hue, got_hsv.sat, got_hsv.value,
                       got_hsv.alpha);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d beats out", cycle_count,
               hsv_beats, pixels_queued);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus: corner pixels, then random phases under changing floors
  initial begin
    int    phase;
    int    mode;
    int    base;
    int    v;
    int    o;
    int    ch [3];
    int    hue_f;
    int    sat_f;
    rgba_t px;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_HUE_DELTA_FLOOR;
    cfg_wdata_i  = 8'h00;
    pix.valid    = 1'b0;
    pix.red_in   = 8'h00;
    pix.green_in = 8'h00;
    pix.blue_in  = 8'h00;
    pix.alpha_in = 8'h00;
    hsv.ready    = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner pixels under the reset floors
    foreach (CORNER_PX[i]) queue_pixel(CORNER_PX[i]);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin hue_f = 0;   sat_f = 0;   sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin hue_f = 255; sat_f = 255; sender_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin
          hue_f = $urandom_range(255); sat_f = $urandom_range(255);
          sender_idle_pct = 0; sink_stall_pct = 60;
        end
        3: begin hue_f = 0;   sat_f = 255; sender_idle_pct = 17; sink_stall_pct = 17; end
        4: begin hue_f = 255; sat_f = 0;   sender_idle_pct = 0;  sink_stall_pct = 0;  end
        5: begin
          hue_f = $urandom_range(12); sat_f = $urandom_range(12);
          sender_idle_pct = 60; sink_stall_pct = 0;
        end
        6: begin hue_f = 1;   sat_f = 1;   sender_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin
          hue_f = 3; sat_f = 3; sender_idle_pct = 17; sink_stall_pct = 17;
        end
      endcase

      // floor writes, block is idle here
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_HUE_DELTA_FLOOR;
      cfg_wdata_i <= 8'(hue_f);
      @(negedge clk_i);
      cfg_idx_i   <= CFG_SAT_VALUE_FLOOR;
      cfg_wdata_i <= 8'(sat_f);
      @(negedge clk_i);
      cfg_we_i    <= 1'b0;
      model_hue_floor = 8'(hue_f);
      model_sat_floor = 8'(sat_f);

      // zero max and zero delta with both floors at zero
      if (phase == 0) begin
        queue_pixel({8'h00, 8'h00, 8'h00, 8'h99});
        queue_pixel({8'h41, 8'h41, 8'h41, 8'h66});
      end

      repeat (BEATS_PER_PHASE) begin
        mode = $urandom_range(9);
        case (mode)
          4: begin
            // gray
            v = $urandom_range(255);
            ch = '{v, v, v};
          end
          5: begin
            // near gray, small delta around the hue floor
            base = $urandom_range(255);
            foreach (ch[k]) begin
              ch[k] = base + int'($urandom_range(8)) - 4;
              if (ch[k] < 0) ch[k] = 0;
              if (ch[k] > 255) ch[k] = 255;
            end
          end
          6: begin
            // dark, max around the saturation floor
            foreach (ch[k]) ch[k] = $urandom_range(7);
          end
          7: begin
            // two channels share the max
            v = $urandom_range(255);
            o = $urandom_range(v);
            case ($urandom_range(2))
              0:       ch = '{v, v, o};
              1:       ch = '{v, o, v};
              default: ch = '{o, v, v};
            endcase
          end
          8: begin
            foreach (ch[k]) ch[k] = int'(rail_or_any());
          end
          9: begin
            // red max with green below blue, hue wraps
            v = $urandom_range(255, 1);
            o = $urandom_range(v - 1);
            ch = '{v, o, $urandom_range(v, o + 1)};
          end
          default: begin
            foreach (ch[k]) ch[k] = $urandom_range(255);
          end
        endcase
        px.red   = 8'(ch[0]);
        px.green = 8'(ch[1]);
        px.blue  = 8'(ch[2]);
        px.alpha = ($urandom_range(9) == 0) ? rail_or_any() : 8'($urandom_range(255));
        queue_pixel(px);
      end
      drain();
    end

    $display("run covered %0d pixels over %0d floor settings,", pixels_in, PHASES + 1);
    $display("with sender gaps and output stalls");
    $display("%0d mismatches, %0d hsv beats still awaited", mismatches,
             hsv_expected_q.size());
    if (mismatches == 0 && hsv_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/r2h_pkg.sv
hdl/r2h_if.sv
hdl/r2h_prep.sv
hdl/r2h_div_stage.sv
hdl/rgb_to_hsv_converter.sv
bench/rgb_to_hsv_converter_tb.sv
